### hw/rtl/pcms_pkg.sv
// Shared types and constants of the per-channel max stretch block.
package pcms_pkg;

   // Pixel component and packed pixel widths
   localparam int unsigned PixW  = 8;
   localparam int unsigned ProdW = 2 * PixW;
   localparam int unsigned DataW = 3 * PixW;
   localparam int unsigned CmdW  = 2;

   // Largest component value, used for saturation
   localparam logic [PixW-1:0] PixMax = {PixW{1'b1}};

   // Item commands carried on tuser
   typedef enum logic [CmdW-1:0] {
      CMD_MEASURE = 2'd0,
      CMD_SCALE   = 2'd1,
      CMD_CLEAR   = 2'd2
   } cmd_type;

   // Channel order within a pixel, lowest bits first
   typedef enum logic [1:0] {
      CH_BLUE  = 2'd0,
      CH_GREEN = 2'd1,
      CH_RED   = 2'd2
   } chan_type;

   // Request from the sequencer to the shared divider
   typedef struct packed {
      logic            start;
      logic [PixW-1:0] x;
      logic [PixW-1:0] peak;
      logic [PixW-1:0] target;
   } div_req_type;

   // Answer from the shared divider
   typedef struct packed {
      logic            done;
      logic [PixW-1:0] value;
   } div_rsp_type;

endpackage

### hw/rtl/pcms_divider.sv
// Shared bit-serial divider: round(target * x / peak), ties to even, clamped to 255.
module pcms_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  pcms_pkg::div_req_type req,
   output pcms_pkg::div_rsp_type rsp
);
   import pcms_pkg::*;

   localparam int unsigned CntW = $clog2(ProdW);
   localparam logic [CntW-1:0] LastStep = CntW'(ProdW - 1);

   typedef enum logic [1:0] {
      D_IDLE,
      D_RUN,
      D_ROUND
   } dstate_type;

   dstate_type       state_ff;
   logic [CntW-1:0]  cnt_ff;
   logic [ProdW-1:0] quo_ff;
   logic [PixW-1:0]  rem_ff;
   logic [PixW-1:0]  den_ff;
   logic             done_ff;
   logic [PixW-1:0]  value_ff;

   logic [PixW:0]    rem_sh;
   logic [PixW:0]    diff;
   logic             fits;
   logic [PixW:0]    twice_rem;
   logic             round_up;
   logic [ProdW:0]   rounded;
   logic [PixW-1:0]  clamped;

   // One restoring step: shift in the next numerator bit, subtract if it fits
   always_comb begin
      rem_sh = {rem_ff, quo_ff[ProdW-1]};
      diff   = rem_sh - {1'b0, den_ff};
      fits   = (rem_sh >= {1'b0, den_ff});
   end

   // Round half to even, then saturate
   always_comb begin
      twice_rem = {rem_ff, 1'b0};
      round_up  = (twice_rem > {1'b0, den_ff}) ||
                  ((twice_rem == {1'b0, den_ff}) && quo_ff[0]);
      rounded   = {1'b0, quo_ff} + {{ProdW{1'b0}}, round_up};
      clamped   = (rounded > {{(ProdW-PixW+1){1'b0}}, PixMax}) ? PixMax : rounded[PixW-1:0];
   end

   // Sequence load, shift steps and rounding
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (req.start) begin
                  if (req.peak == '0) begin
                     // Zero peak: any nonzero input saturates
                     value_ff <= (req.x != '0) ? PixMax : '0;
                     done_ff  <= 1'b1;
                  end else begin
                     quo_ff   <= {{PixW{1'b0}}, req.target} * {{PixW{1'b0}}, req.x};
                     rem_ff   <= '0;
                     den_ff   <= req.peak;
                     cnt_ff   <= '0;
                     state_ff <= D_RUN;
                  end
               end
            end
            D_RUN: begin
               quo_ff <= {quo_ff[ProdW-2:0], fits};
               rem_ff <= fits ? diff[PixW-1:0] : rem_sh[PixW-1:0];
               cnt_ff <= cnt_ff + CntW'(1);
               if (cnt_ff == LastStep) begin
                  state_ff <= D_ROUND;
               end
            end
            D_ROUND: begin
               value_ff <= clamped;
               done_ff  <= 1'b1;
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

endmodule

### hw/rtl/per_channel_max_stretch_core.sv
// Top level of the per-channel max stretch block: peaks, sequencer and output register.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_tvalid/tready     tuser: command; tdata: blue, green, red
//   rsp      out        rsp_tvalid/tready     tdata: blue, green, red
//   csr      in         csr_wr_en             csr_wr_data: target peak
//
// Measure and clear beats update the peaks as they are accepted, and the block stays
// ready. A scale beat runs the three channels one after another through the shared
// divider: load, 16 quotient bits, round and hand-back per channel with a nonzero
// peak, a direct answer with a zero peak, then the output register is loaded.
// Synchronous reset clears the peaks to zero and the target peak to 255.
// A stalled result waits in the output register; the next item is taken meanwhile,
// and a following scale result waits for the register to empty.
module per_channel_max_stretch_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pcms_pkg::DataW-1:0]    req_tdata,   // blue_in, green_in, red_in
   input  logic [pcms_pkg::CmdW-1:0]     req_tuser,   // command
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pcms_pkg::DataW-1:0]    rsp_tdata,   // blue_out, green_out, red_out
   input  logic                          csr_wr_en,
   input  logic [pcms_pkg::PixW-1:0]     csr_wr_data
);
   import pcms_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_WAIT,
      S_EMIT
   } state_type;

   state_type       state_ff;
   chan_type        chan_ff;
   logic [PixW-1:0] target_ff;
   logic [PixW-1:0] peak_ff [3];
   logic [PixW-1:0] pix_ff  [3];
   logic [PixW-1:0] res_ff  [3];
   logic            rsp_valid_ff;
   logic [DataW-1:0] rsp_data_ff;

   logic [PixW-1:0] in_pix [3];
   logic            accept;
   logic            emit_load;
   cmd_type         cmd;
   div_req_type     div_req;
   div_rsp_type     div_rsp;

   // Unpack the beat
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_pix[i] = req_tdata[i*PixW +: PixW];
      end
      cmd = cmd_type'(req_tuser);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign emit_load  = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);

   // Feed the divider the current channel
   always_comb begin
      div_req.start  = (state_ff == S_ISSUE);
      div_req.x      = pix_ff[chan_ff];
      div_req.peak   = peak_ff[chan_ff];
      div_req.target = target_ff;
   end

   pcms_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Target peak register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= PixMax;
      end else if (csr_wr_en) begin
         target_ff <= csr_wr_data;
      end
   end

   // Sequencer, peaks and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chan_ff      <= CH_BLUE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            peak_ff[i] <= '0;
         end
      end else begin
         // Load a finished pixel, or drop the result once taken
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (cmd)
                     CMD_MEASURE: begin
                        for (int i = 0; i < 3; i++) begin
                           if (in_pix[i] > peak_ff[i]) begin
                              peak_ff[i] <= in_pix[i];
                           end
                        end
                     end
                     CMD_SCALE: begin
                        for (int i = 0; i < 3; i++) begin
                           pix_ff[i] <= in_pix[i];
                        end
                        chan_ff  <= CH_BLUE;
                        state_ff <= S_ISSUE;
                     end
                     CMD_CLEAR: begin
                        for (int i = 0; i < 3; i++) begin
                           peak_ff[i] <= '0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_ISSUE: state_ff <= S_WAIT;
            S_WAIT: begin
               if (div_rsp.done) begin
                  res_ff[chan_ff] <= div_rsp.value;
                  unique case (chan_ff)
                     CH_BLUE:  begin chan_ff <= CH_GREEN; state_ff <= S_ISSUE; end
                     CH_GREEN: begin chan_ff <= CH_RED;   state_ff <= S_ISSUE; end
                     default:  state_ff <= S_EMIT;
                  endcase
               end
            end
            S_EMIT: begin
               // Load once the output register is free
               if (emit_load) begin
                  rsp_data_ff <= {res_ff[2], res_ff[1], res_ff[0]};
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### tb/per_channel_max_stretch_core_tb.sv
// Self-checking testbench of the per-channel max stretch core with random traffic and stalls.
`timescale 1ns / 100ps

module per_channel_max_stretch_core_tb;
   import pcms_pkg::*;

   // Command code that the block must ignore
   localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

   localparam int unsigned RESET_CYCLES  = 7;
   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned TAIL_CYCLES   = 80;
   localparam int unsigned RANDOM_ITEMS  = 1900;

   // Pixel as it travels on tdata, blue in the lowest bits
   typedef struct packed {
      logic [PixW-1:0] red;
      logic [PixW-1:0] green;
      logic [PixW-1:0] blue;
   } pixel_type;

   // One entry for the driver: either a pixel beat or a target peak write
   typedef struct {
      logic            to_csr;
      logic [PixW-1:0] target;
      logic [CmdW-1:0] cmd;
      pixel_type       pix;
   } feed_entry_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [DataW-1:0]    req_tdata   = '0;   // blue_in, green_in, red_in
   logic [CmdW-1:0]     req_tuser   = '0;   // command
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [DataW-1:0]    rsp_tdata;          // blue_out, green_out, red_out
   logic                csr_wr_en   = 1'b0;
   logic [PixW-1:0]     csr_wr_data = '0;

   feed_entry_type      feed_q[$];
   pixel_type           stretched_q[$];

   // Predictor state
   logic [PixW-1:0]     target_now;
   logic [PixW-1:0]     peak_blue;
   logic [PixW-1:0]     peak_green;
   logic [PixW-1:0]     peak_red;

   logic                req_taken = 1'b0;
   logic                rsp_taken = 1'b0;
   logic                send_steady = 1'b0;
   logic                recv_steady = 1'b0;
   int unsigned         send_gap;
   int unsigned         recv_stall;
   int unsigned         idle_cycles;
   int unsigned         items_made;
   int unsigned         error_count;
   int unsigned         n_measure, n_scale, n_clear, n_unused, n_csr, n_checked;

   string               chan_name[3] = '{"blue", "green", "red"};

   per_channel_max_stretch_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stretch one channel: round(target * x / peak), ties to even, saturated
   function automatic logic [PixW-1:0] stretch_chan(logic [PixW-1:0] x, logic [PixW-1:0] peak,
                                                    logic [PixW-1:0] tgt);
      logic [ProdW-1:0] den;
      logic [ProdW-1:0] prod;
      logic [ProdW-1:0] quo;
      logic [ProdW-1:0] rem;
      logic [ProdW:0]   twice_rem;
      if (peak == '0)
         return (x == '0) ? '0 : PixMax;
      den       = ProdW'(peak);
      prod      = ProdW'(tgt) * ProdW'(x);
      quo       = prod / den;
      rem       = prod % den;
      twice_rem = {rem, 1'b0};
      if (twice_rem > {1'b0, den} || (twice_rem == {1'b0, den} && quo[0]))
         quo = quo + ProdW'(1);
      return (quo > ProdW'(PixMax)) ? PixMax : quo[PixW-1:0];
   endfunction

   // Gap length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Any component value
   function automatic logic [PixW-1:0] pick_any();
      return PixW'($urandom_range(0, 255));
   endfunction

   // Channel value: small values make small peaks and frequent exact halves
   function automatic logic [PixW-1:0] pick_chan(logic narrow);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (narrow && roll < 7) return PixW'($urandom_range(0, 15));
      if (roll == 7) return '0;
      if (roll == 8) return PixMax;
      return pick_any();
   endfunction

   task automatic add_item(logic [CmdW-1:0] cmd, logic [PixW-1:0] b, logic [PixW-1:0] g,
                           logic [PixW-1:0] r);
      feed_entry_type e;
      e.to_csr    = 1'b0;
      e.target    = '0;
      e.cmd       = cmd;
      e.pix.blue  = b;
      e.pix.green = g;
      e.pix.red   = r;
      feed_q.push_back(e);
      if (cmd != CMD_UNUSED) items_made++;
   endtask

   task automatic add_target(logic [PixW-1:0] value);
      feed_entry_type e;
      e.to_csr = 1'b1;
      e.target = value;
      e.cmd    = CMD_MEASURE;
      e.pix    = '0;
      feed_q.push_back(e);
   endtask

   // Request driver: present beats and target writes at the falling edge
   always @(negedge clock) begin : feed_driver
      feed_entry_type head;
      logic        nxt_valid;
      logic        nxt_wr;
      nxt_valid = req_tvalid;
      nxt_wr    = 1'b0;
      if (reset) begin
         nxt_valid   = 1'b0;
         send_gap    = 0;
         idle_cycles = 0;
      end else begin
         // drop the beat once taken and choose the next gap
         if (req_tvalid && req_taken) begin
            nxt_valid = 1'b0;
            if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
            send_gap = send_steady ? 0 : pick_gap();
         end
         // count cycles with nothing in flight
         if (!nxt_valid && stretched_q.size() == 0)
            idle_cycles++;
         else
            idle_cycles = 0;
         if (!nxt_valid && feed_q.size() > 0) begin
            if (feed_q[0].to_csr) begin
               // write the target only once the block has settled
               if (idle_cycles > SETTLE_CYCLES) begin
                  head        = feed_q.pop_front();
                  nxt_wr      = 1'b1;
                  csr_wr_data <= head.target;
                  idle_cycles = 0;
               end
            end else if (send_gap > 0) begin
               send_gap--;
            end else begin
               head      = feed_q.pop_front();
               nxt_valid = 1'b1;
               req_tuser <= head.cmd;
               req_tdata <= head.pix;
            end
         end
      end
      req_tvalid <= nxt_valid;
      csr_wr_en  <= nxt_wr;
   end

   // Result receiver: random stalls, with stretches of none
   always @(negedge clock) begin : rsp_receiver
      logic nxt_ready;
      if (reset) begin
         nxt_ready  = 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 63) == 0) recv_steady = !recv_steady;
            recv_stall = recv_steady ? 0 : pick_gap();
         end
         if (recv_stall > 0) begin
            recv_stall--;
            nxt_ready = 1'b0;
         end else begin
            nxt_ready = 1'b1;
         end
      end
      rsp_tready <= nxt_ready;
   end

   // Monitor: predict on accepted beats, check results at the rising edge
   always @(posedge clock) begin : beat_monitor
      pixel_type in_pix;
      pixel_type want;
      pixel_type seen;
      req_taken <= req_tvalid && req_tready;
      rsp_taken <= rsp_tvalid && rsp_tready;
      if (reset) begin
         target_now = PixMax;
         peak_blue  = '0;
         peak_green = '0;
         peak_red   = '0;
      end else begin
         if (csr_wr_en) begin
            target_now = csr_wr_data;
            n_csr++;
         end
         if (req_tvalid && req_tready) begin
            in_pix = req_tdata;
            case (req_tuser)
               CMD_MEASURE: begin
                  if (in_pix.blue > peak_blue) peak_blue = in_pix.blue;
                  if (in_pix.green > peak_green) peak_green = in_pix.green;
                  if (in_pix.red > peak_red) peak_red = in_pix.red;
                  n_measure++;
               end
               CMD_SCALE: begin
                  want.blue  = stretch_chan(in_pix.blue, peak_blue, target_now);
                  want.green = stretch_chan(in_pix.green, peak_green, target_now);
                  want.red   = stretch_chan(in_pix.red, peak_red, target_now);
                  stretched_q.push_back(want);
                  n_scale++;
               end
               CMD_CLEAR: begin
                  peak_blue  = '0;
                  peak_green = '0;
                  peak_red   = '0;
                  n_clear++;
               end
               default: n_unused++;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (stretched_q.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, got %h", $time, seen);
               error_count++;
            end else begin
               want = stretched_q.pop_front();
               n_checked++;
               for (int c = 0; c < 3; c++) begin
                  if (seen[c*PixW +: PixW] !== want[c*PixW +: PixW]) begin
                     $display("%0t: %s mismatch, expected %0d, got %0d", $time, chan_name[c],
                              want[c*PixW +: PixW], seen[c*PixW +: PixW]);
                     error_count++;
                  end
               end
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin : run_control
      int unsigned n;
      int unsigned roll;
      logic        narrow;
      logic [PixW-1:0] tgt;
      items_made  = 0;
      error_count = 0;
      n_measure = 0; n_scale = 0; n_clear = 0; n_unused = 0; n_csr = 0; n_checked = 0;

      // Directed: zero peaks, exact halves, saturation, ignored command, target extremes
      add_item(CMD_SCALE, 8'd0, 8'd255, 8'd1);
      add_item(CMD_MEASURE, 8'd255, 8'd200, 8'd2);
      add_item(CMD_MEASURE, 8'd0, 8'd0, 8'd0);
      add_item(CMD_SCALE, 8'd255, 8'd200, 8'd1);
      add_item(CMD_SCALE, 8'd128, 8'd100, 8'd2);
      add_item(CMD_SCALE, 8'd0, 8'd0, 8'd0);
      add_item(CMD_UNUSED, 8'd255, 8'd255, 8'd255);
      add_item(CMD_SCALE, 8'd1, 8'd1, 8'd1);
      add_item(CMD_CLEAR, 8'd255, 8'd255, 8'd255);
      add_item(CMD_SCALE, 8'd0, 8'd7, 8'd0);
      add_item(CMD_MEASURE, 8'd10, 8'd3, 8'd100);
      add_item(CMD_SCALE, 8'd255, 8'd255, 8'd255);
      add_item(CMD_SCALE, 8'd5, 8'd1, 8'd50);
      add_target(8'd0);
      add_item(CMD_SCALE, 8'd255, 8'd0, 8'd77);
      add_item(CMD_SCALE, 8'd0, 8'd3, 8'd200);
      add_target(8'd1);
      add_item(CMD_SCALE, 8'd5, 8'd2, 8'd50);
      add_item(CMD_SCALE, 8'd15, 8'd3, 8'd150);
      add_target(8'd200);
      add_item(CMD_MEASURE, 8'd255, 8'd255, 8'd255);
      add_item(CMD_SCALE, 8'd128, 8'd51, 8'd255);
      add_item(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
      add_item(CMD_MEASURE, 8'd1, 8'd0, 8'd1);
      add_item(CMD_SCALE, 8'd1, 8'd0, 8'd1);
      add_target(8'd255);
      add_item(CMD_SCALE, 8'd1, 8'd9, 8'd0);

      // Random: per phase a new target, a measure pass, then a scale pass with some noise
      while (items_made < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 7);
         case (roll)
            0:       tgt = '0;
            1:       tgt = PixMax;
            2:       tgt = 8'd1;
            default: tgt = pick_any();
         endcase
         add_target(tgt);
         narrow = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 4) != 0)
            add_item(CMD_CLEAR, pick_any(), pick_any(), pick_any());
         n = $urandom_range(1, 12);
         repeat (n) add_item(CMD_MEASURE, pick_chan(narrow), pick_chan(narrow), pick_chan(narrow));
         n = $urandom_range(1, 24);
         repeat (n) begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
               add_item(CMD_UNUSED, pick_any(), pick_any(), pick_any());
            else if (roll == 1)
               add_item(CMD_MEASURE, pick_chan(narrow), pick_chan(narrow), pick_chan(narrow));
            else if (roll == 2)
               add_item(CMD_CLEAR, pick_any(), pick_any(), pick_any());
            else
               add_item(CMD_SCALE, pick_chan(narrow), pick_chan(narrow), pick_chan(narrow));
         end
      end

      // Hold reset, release it at a falling edge
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Drain: all beats sent, all results back, then a quiet tail
      while (feed_q.size() != 0 || req_tvalid || csr_wr_en) @(posedge clock);
      while (stretched_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (stretched_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, stretched_q.size());
         error_count++;
      end

      $display("Ran %0d measure, %0d scale, %0d clear and %0d ignored beats over %0d targets;",
               n_measure, n_scale, n_clear, n_unused, n_csr);
      $display("checked %0d stretched pixels, %0d errors.", n_checked, error_count);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #20_000_000;
      $display("%0t: run did not finish in time", $time);
      $display("TEST FAILED");
      $finish;
   end

endmodule
